FILE: rtl/core/mi3_pkg.sv
package mi3_pkg;

   // default element width and fixed-point scaling
   localparam int ELEM_WIDTH_DEF = 16;
   localparam int FRAC_IN        = 8;
   localparam int OUT_FRAC       = 16;
   localparam int NUM_SHIFT      = FRAC_IN + OUT_FRAC;
   localparam int OUT_WIDTH      = 32;
   // quotient bits kept: one above the output width so saturation can be decided
   localparam int Q_BITS         = OUT_WIDTH + 1;
   localparam int NUM_ELEM       = 9;

   // pipeline latency from accepted beat to result strobe
   localparam int LATENCY        = 7 + Q_BITS;

   localparam logic [OUT_WIDTH-1:0] SAT_POS = {1'b0, {(OUT_WIDTH-1){1'b1}}};
   localparam logic [OUT_WIDTH-1:0] SAT_NEG = {1'b1, {(OUT_WIDTH-1){1'b0}}};

   // adjugate entry k = m[a]*m[b] - m[c]*m[d], element index = row + 3*col
   localparam int ADJ_IDX [NUM_ELEM][4] = '{
      '{4, 8, 5, 7},
      '{2, 7, 1, 8},
      '{1, 5, 2, 4},
      '{5, 6, 3, 8},
      '{0, 8, 2, 6},
      '{2, 3, 0, 5},
      '{3, 7, 4, 6},
      '{1, 6, 0, 7},
      '{0, 4, 1, 3}
   };

   // control bits carried with each divider lane
   typedef struct packed {
      logic valid;
      logic neg;
      logic sing;
   } mi3_ctl_type;

endpackage

FILE: rtl/core/matrix_inverse_3x3_core.sv
// 3x3 inverse by adjugate over determinant, Q8.8 in, Q16.16 saturated out
// path from accepted start to rsp_strobe: adjugate stages, determinant stages, then the divider lanes
// throughput: one matrix per cycle, busy is never raised
// the result receiver cannot stall, so the pipeline never holds
// reset (synchronous) clears all valid bits; payload registers are not reset
module matrix_inverse_3x3_core #(
   parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [ELEM_WIDTH-1:0]        req_r0c0,
   input  logic signed [ELEM_WIDTH-1:0]        req_r1c0,
   input  logic signed [ELEM_WIDTH-1:0]        req_r2c0,
   input  logic signed [ELEM_WIDTH-1:0]        req_r0c1,
   input  logic signed [ELEM_WIDTH-1:0]        req_r1c1,
   input  logic signed [ELEM_WIDTH-1:0]        req_r2c1,
   input  logic signed [ELEM_WIDTH-1:0]        req_r0c2,
   input  logic signed [ELEM_WIDTH-1:0]        req_r1c2,
   input  logic signed [ELEM_WIDTH-1:0]        req_r2c2,
   output logic                                rsp_strobe,
   output logic signed [mi3_pkg::OUT_WIDTH-1:0] rsp_r0c0,
   output logic signed [mi3_pkg::OUT_WIDTH-1:0] rsp_r1c0,
   output logic signed [mi3_pkg::OUT_WIDTH-1:0] rsp_r2c0,
   output logic signed [mi3_pkg::OUT_WIDTH-1:0] rsp_r0c1,
   output logic signed [mi3_pkg::OUT_WIDTH-1:0] rsp_r1c1,
   output logic signed [mi3_pkg::OUT_WIDTH-1:0] rsp_r2c1,
   output logic signed [mi3_pkg::OUT_WIDTH-1:0] rsp_r0c2,
   output logic signed [mi3_pkg::OUT_WIDTH-1:0] rsp_r1c2,
   output logic signed [mi3_pkg::OUT_WIDTH-1:0] rsp_r2c2,
   output logic                                rsp_singular
);

   localparam int W  = ELEM_WIDTH;
   localparam int AW = 2 * W + 1;
   localparam int DW = 3 * W + 3;
   localparam int NE = mi3_pkg::NUM_ELEM;

   logic signed [W-1:0]   elem [NE];
   logic                  accept;
   logic                  adj_valid;
   logic signed [AW-1:0]  adj [NE];
   logic signed [W-1:0]   row0 [3];
   logic                  det_valid;
   logic [AW-1:0]         nmag [NE];
   logic                  nneg [NE];
   logic [DW-1:0]         dmag;
   logic                  sing;
   mi3_pkg::mi3_ctl_type  lane_ctl [NE];
   mi3_pkg::mi3_ctl_type  res_ctl [NE];
   logic [mi3_pkg::OUT_WIDTH-1:0] res [NE];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // element order is row + 3*col
   assign elem[0] = req_r0c0;
   assign elem[1] = req_r1c0;
   assign elem[2] = req_r2c0;
   assign elem[3] = req_r0c1;
   assign elem[4] = req_r1c1;
   assign elem[5] = req_r2c1;
   assign elem[6] = req_r0c2;
   assign elem[7] = req_r1c2;
   assign elem[8] = req_r2c2;

   // adjugate stages
   mi3_adj #(.ELEM_WIDTH(ELEM_WIDTH)) u_adj (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_elem   (elem),
      .out_valid (adj_valid),
      .out_adj   (adj),
      .out_row0  (row0)
   );

   // determinant stages
   mi3_det #(.ELEM_WIDTH(ELEM_WIDTH)) u_det (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (adj_valid),
      .in_adj    (adj),
      .in_row0   (row0),
      .out_valid (det_valid),
      .out_nmag  (nmag),
      .out_nneg  (nneg),
      .out_dmag  (dmag),
      .out_sing  (sing)
   );

   // nine divider lanes
   for (genvar k = 0; k < NE; k++) begin : g_lane
      assign lane_ctl[k].valid = det_valid;
      assign lane_ctl[k].neg   = nneg[k];
      assign lane_ctl[k].sing  = sing;

      mi3_div_lane #(.ELEM_WIDTH(ELEM_WIDTH)) u_lane (
         .clock     (clock),
         .reset     (reset),
         .in_ctl    (lane_ctl[k]),
         .in_nmag   (nmag[k]),
         .in_dmag   (dmag),
         .out_ctl   (res_ctl[k]),
         .out_value (res[k])
      );
   end

   assign rsp_strobe   = res_ctl[0].valid;
   assign rsp_singular = res_ctl[0].valid && res_ctl[0].sing;
   assign rsp_r0c0     = res[0];
   assign rsp_r1c0     = res[1];
   assign rsp_r2c0     = res[2];
   assign rsp_r0c1     = res[3];
   assign rsp_r1c1     = res[4];
   assign rsp_r2c1     = res[5];
   assign rsp_r0c2     = res[6];
   assign rsp_r1c2     = res[7];
   assign rsp_r2c2     = res[8];

`ifndef SYNTHESIS
   a_strobe_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept && !reset, mi3_pkg::LATENCY))
      else $error("result strobe without matching accepted beat");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_singular |-> (rsp_r0c0 == 0 && rsp_r1c1 == 0 && rsp_r2c2 == 0 &&
                        rsp_r2c0 == 0 && rsp_r0c2 == 0))
      else $error("singular result with nonzero elements");

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (res_ctl[4].valid && res_ctl[8].valid &&
                      res_ctl[4].sing == res_ctl[0].sing))
      else $error("divider lanes out of step");
`endif

endmodule

FILE: rtl/core/mi3_adj.sv
module mi3_adj #(
   parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [ELEM_WIDTH-1:0] in_elem [mi3_pkg::NUM_ELEM],
   output logic                         out_valid,
   output logic signed [2*ELEM_WIDTH:0] out_adj [mi3_pkg::NUM_ELEM],
   output logic signed [ELEM_WIDTH-1:0] out_row0 [3]
);

   localparam int W  = ELEM_WIDTH;
   localparam int PW = 2 * W;
   localparam int AW = 2 * W + 1;

   logic                 v1_ff, v2_ff, v3_ff;
   logic signed [W-1:0]  m_ff [mi3_pkg::NUM_ELEM];
   logic signed [PW-1:0] pa_ff [mi3_pkg::NUM_ELEM];
   logic signed [PW-1:0] pb_ff [mi3_pkg::NUM_ELEM];
   logic signed [W-1:0]  r0a_ff [3];
   logic signed [W-1:0]  r0b_ff [3];
   logic signed [AW-1:0] adj_ff [mi3_pkg::NUM_ELEM];

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      m_ff <= in_elem;
   end

   // minor products, then differences
   for (genvar k = 0; k < mi3_pkg::NUM_ELEM; k++) begin : g_minor
      always_ff @(posedge clock) begin
         pa_ff[k]  <= m_ff[mi3_pkg::ADJ_IDX[k][0]] * m_ff[mi3_pkg::ADJ_IDX[k][1]];
         pb_ff[k]  <= m_ff[mi3_pkg::ADJ_IDX[k][2]] * m_ff[mi3_pkg::ADJ_IDX[k][3]];
         adj_ff[k] <= {pa_ff[k][PW-1], pa_ff[k]} - {pb_ff[k][PW-1], pb_ff[k]};
      end
   end

   // first column rides along for the determinant
   for (genvar j = 0; j < 3; j++) begin : g_row0
      always_ff @(posedge clock) begin
         r0a_ff[j] <= m_ff[j];
         r0b_ff[j] <= r0a_ff[j];
      end
   end

   assign out_valid = v3_ff;
   assign out_adj   = adj_ff;
   assign out_row0  = r0b_ff;

endmodule

FILE: rtl/core/mi3_det.sv
module mi3_det #(
   parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [2*ELEM_WIDTH:0] in_adj [mi3_pkg::NUM_ELEM],
   input  logic signed [ELEM_WIDTH-1:0] in_row0 [3],
   output logic                         out_valid,
   output logic        [2*ELEM_WIDTH:0] out_nmag [mi3_pkg::NUM_ELEM],
   output logic                         out_nneg [mi3_pkg::NUM_ELEM],
   output logic      [3*ELEM_WIDTH+2:0] out_dmag,
   output logic                         out_sing
);

   localparam int W   = ELEM_WIDTH;
   localparam int AW  = 2 * W + 1;
   localparam int XW  = W + AW;
   localparam int DW  = 3 * W + 3;

   logic                 v1_ff, v2_ff;
   logic signed [XW-1:0] dp_ff [3];
   logic signed [AW-1:0] adj_ff [mi3_pkg::NUM_ELEM];
   logic signed [DW-1:0] det_sum;
   logic                 dneg;
   logic        [AW-1:0] nmag_ff [mi3_pkg::NUM_ELEM];
   logic                 nneg_ff [mi3_pkg::NUM_ELEM];
   logic        [DW-1:0] dmag_ff;
   logic                 sing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   // cofactor expansion along the first column
   for (genvar j = 0; j < 3; j++) begin : g_dprod
      always_ff @(posedge clock) begin
         dp_ff[j] <= in_row0[j] * in_adj[3*j];
      end
   end

   always_ff @(posedge clock) begin
      adj_ff <= in_adj;
   end

   // determinant sum and sign
   assign det_sum = {{(DW-XW){dp_ff[0][XW-1]}}, dp_ff[0]}
                  + {{(DW-XW){dp_ff[1][XW-1]}}, dp_ff[1]}
                  + {{(DW-XW){dp_ff[2][XW-1]}}, dp_ff[2]};
   assign dneg = det_sum[DW-1];

   always_ff @(posedge clock) begin
      dmag_ff <= dneg ? DW'(-det_sum) : DW'(det_sum);
      sing_ff <= (det_sum == '0);
   end

   // adjugate magnitudes and quotient signs
   for (genvar k = 0; k < mi3_pkg::NUM_ELEM; k++) begin : g_nmag
      always_ff @(posedge clock) begin
         nmag_ff[k] <= adj_ff[k][AW-1] ? AW'(-adj_ff[k]) : AW'(adj_ff[k]);
         nneg_ff[k] <= adj_ff[k][AW-1] ^ dneg;
      end
   end

   assign out_valid = v2_ff;
   assign out_nmag  = nmag_ff;
   assign out_nneg  = nneg_ff;
   assign out_dmag  = dmag_ff;
   assign out_sing  = sing_ff;

endmodule

FILE: rtl/core/mi3_div_lane.sv
module mi3_div_lane #(
   parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mi3_pkg::mi3_ctl_type              in_ctl,
   input  logic           [2*ELEM_WIDTH:0]   in_nmag,
   input  logic           [3*ELEM_WIDTH+2:0] in_dmag,
   output mi3_pkg::mi3_ctl_type              out_ctl,
   output logic [mi3_pkg::OUT_WIDTH-1:0]     out_value
);

   localparam int W   = ELEM_WIDTH;
   localparam int DW  = 3 * W + 3;
   localparam int QB  = mi3_pkg::Q_BITS;
   localparam int RW  = DW + QB;
   localparam int OW  = mi3_pkg::OUT_WIDTH;

   mi3_pkg::mi3_ctl_type ctl_ff [QB+1];
   logic                 ovf_ff [QB+1];
   logic [RW-1:0]        r_ff [QB+1];
   logic [QB-1:0]        q_ff [QB+1];
   logic [DW-1:0]        d_ff [QB+1];
   logic [RW-1:0]        n_ext;
   mi3_pkg::mi3_ctl_type oc_ff;
   logic [OW-1:0]        ov_ff;
   logic [OW-1:0]        res_in;
   logic [QB-1:0]        qf;

   // scaled numerator and early overflow check
   assign n_ext = RW'(in_nmag) << mi3_pkg::NUM_SHIFT;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0].valid <= 1'b0;
      end else begin
         ctl_ff[0].valid <= in_ctl.valid;
      end
      ctl_ff[0].neg  <= in_ctl.neg;
      ctl_ff[0].sing <= in_ctl.sing;
      ovf_ff[0]      <= (n_ext >= {in_dmag, {QB{1'b0}}});
      r_ff[0]        <= n_ext;
      q_ff[0]        <= '0;
      d_ff[0]        <= in_dmag;
   end

   // restoring division, one quotient bit per stage, msb first
   for (genvar k = 0; k < QB; k++) begin : g_stage
      localparam int BI = QB - 1 - k;
      logic [RW-1:0] sh;
      logic [RW:0]   diff;

      assign sh   = RW'(d_ff[k]) << BI;
      assign diff = {1'b0, r_ff[k]} - {1'b0, sh};

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k+1].valid <= 1'b0;
         end else begin
            ctl_ff[k+1].valid <= ctl_ff[k].valid;
         end
         ctl_ff[k+1].neg  <= ctl_ff[k].neg;
         ctl_ff[k+1].sing <= ctl_ff[k].sing;
         ovf_ff[k+1]      <= ovf_ff[k];
         d_ff[k+1]        <= d_ff[k];
         r_ff[k+1]        <= diff[RW] ? r_ff[k] : diff[RW-1:0];
         q_ff[k+1]        <= q_ff[k] | (QB'(!diff[RW]) << BI);
      end
   end

   // sign, saturation and singular zeroing
   assign qf = q_ff[QB];

   always_comb begin
      priority if (ctl_ff[QB].sing) begin
         res_in = '0;
      end else if (ctl_ff[QB].neg) begin
         if (ovf_ff[QB] || qf > QB'(mi3_pkg::SAT_NEG)) begin
            res_in = mi3_pkg::SAT_NEG;
         end else begin
            res_in = OW'(-qf);
         end
      end else begin
         if (ovf_ff[QB] || qf > QB'(mi3_pkg::SAT_POS)) begin
            res_in = mi3_pkg::SAT_POS;
         end else begin
            res_in = qf[OW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oc_ff.valid <= 1'b0;
      end else begin
         oc_ff.valid <= ctl_ff[QB].valid;
      end
      oc_ff.neg  <= ctl_ff[QB].neg;
      oc_ff.sing <= ctl_ff[QB].sing;
      ov_ff      <= res_in;
   end

   assign out_ctl   = oc_ff;
   assign out_value = ov_ff;

endmodule
